// ===== rtl/lcs_pkg.sv =====
// Shared types and codes for the longest common subsequence block.
package lcs_pkg;

    // Width of every length, row and column value on the result ports.
    localparam int LEN_W = 6;
    // Width of the traceback result counter.
    localparam int CNT_W = 7;
    // Width of the symbol field on the input port.
    localparam int SYM_W = 16;

    // Operation codes.
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_FEED  = 2'd1;
    localparam logic [1:0] OP_TRACE = 2'd2;

    // Direction codes of a table cell.
    localparam logic [1:0] DIR_EDGE = 2'd0;
    localparam logic [1:0] DIR_DIAG = 2'd1;
    localparam logic [1:0] DIR_UP   = 2'd2;
    localparam logic [1:0] DIR_LEFT = 2'd3;

    // One input item.
    typedef struct packed {
        logic [1:0]        operation;
        logic signed [SYM_W-1:0] symbol;
        logic              first;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic [LEN_W-1:0] row;
        logic [LEN_W-1:0] col;
        logic [1:0]       direction;
        logic             overflow;
        logic             last;
    } result_t;

    // Wavefront token handed from one cell to the next.
    typedef struct packed {
        logic             active;
        logic [LEN_W-1:0] left_new;
        logic [LEN_W-1:0] left_old;
    } token_t;

    // Broadcast controls from the sequencer to every cell.
    typedef struct packed {
        logic clear_rows;
        logic load;
    } cell_ctrl_t;

    // What the active cell reports back; zero from inactive cells.
    typedef struct packed {
        logic [LEN_W-1:0] value;
        logic [1:0]       direction;
    } cell_out_t;

endpackage

// ===== rtl/lcs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lcs_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/lcs_cell.sv =====
// One column cell: holds one B symbol and that column's latest row length.
module lcs_cell #(
    parameter int SYMBOL_WIDTH = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lcs_pkg::cell_ctrl_t     ctrl,
    input  logic                    load_sel,
    input  logic                    used,
    input  logic [SYMBOL_WIDTH-1:0] load_symbol,
    input  logic [SYMBOL_WIDTH-1:0] cmp_symbol,
    input  lcs_pkg::token_t         tok_in,
    output lcs_pkg::token_t         tok_out,
    output lcs_pkg::cell_out_t      cell_out
);

    logic [SYMBOL_WIDTH-1:0]   seq_reg;
    logic [lcs_pkg::LEN_W-1:0] len_reg;
    logic [lcs_pkg::LEN_W-1:0] len_next;
    lcs_pkg::token_t           tok_reg;
    lcs_pkg::token_t           tok_next;
    logic                      act;
    logic [lcs_pkg::LEN_W-1:0] new_value;
    logic [1:0]                new_dir;

    // Cell update: match takes the diagonal, otherwise upper wins ties.
    always_comb
    begin
        act = tok_in.active && used;
        if (cmp_symbol == seq_reg)
        begin
            new_value = tok_in.left_old + lcs_pkg::LEN_W'(1);
            new_dir   = lcs_pkg::DIR_DIAG;
        end
        else if (len_reg >= tok_in.left_new)
        begin
            new_value = len_reg;
            new_dir   = lcs_pkg::DIR_UP;
        end
        else
        begin
            new_value = tok_in.left_new;
            new_dir   = lcs_pkg::DIR_LEFT;
        end

        if (ctrl.clear_rows)
        begin
            len_next = '0;
        end
        else if (act)
        begin
            len_next = new_value;
        end
        else
        begin
            len_next = len_reg;
        end

        tok_next.active   = act;
        tok_next.left_new = new_value;
        tok_next.left_old = len_reg;

        cell_out.value     = act ? new_value : '0;
        cell_out.direction = act ? new_dir : lcs_pkg::DIR_EDGE;
    end

    // Row length and outgoing token.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            tok_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
            tok_reg <= tok_next;
        end
    end

    // Stored symbol.
    always_ff @(posedge clk)
    begin
        if (ctrl.load && load_sel)
        begin
            seq_reg <= load_symbol;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== rtl/lcs_table_and_traceback.sv =====
// Top level: sequencer, chain of column cells and direction memory for LCS.
//
//  Channel  | Ports                  | Transfer
//  ---------+------------------------+------------------------------------
//  input    | start, busy, item      | edge with start high and busy low
//  result   | strobe, result         | every edge that ends a strobe cycle
//
// A load, a feed that finds B empty or a sequence full, and an unused code
// give one result in the cycle after the transfer. A feed computes its row
// as a wavefront through the cells, one column a cycle, and gives its result
// once the last column of B is done. A traceback reads the direction memory
// through an address state and a data state for each path cell, and a path
// that reaches row 0 or column 0 closes with a result for its edge cell.
// Reset clears lengths and control; no clearing pass is needed. The
// receiver cannot stall, and busy is low again when the last result shows.
module lcs_table_and_traceback #(
    parameter int MAX_LEN      = 32,
    parameter int SYMBOL_WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  lcs_pkg::item_t   item,
    output logic             busy,
    output logic             strobe,
    output lcs_pkg::result_t result
);

    localparam int DEPTH = MAX_LEN * MAX_LEN;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = lcs_pkg::LEN_W;

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_ROW     = 2'd1;
    localparam logic [1:0] S_TR_ADDR = 2'd2;
    localparam logic [1:0] S_TR_DATA = 2'd3;

    logic [1:0]                state_reg, state_next;
    logic [LW-1:0]             b_len_reg, b_len_next;
    logic [LW-1:0]             a_len_reg, a_len_next;
    logic [LW-1:0]             len_reg, len_next;
    logic [LW-1:0]             col_reg, col_next;
    logic [LW-1:0]             tr_i_reg, tr_i_next;
    logic [LW-1:0]             tr_j_reg, tr_j_next;
    logic [lcs_pkg::CNT_W-1:0] tr_k_reg, tr_k_next;
    logic [SYMBOL_WIDTH-1:0]   sym_reg, sym_next;
    lcs_pkg::token_t           tok0_reg, tok0_next;
    lcs_pkg::result_t          res_reg, res_next;
    logic                      strobe_reg, strobe_next;

    logic                      accept;
    logic [LW-1:0]             b_eff, a_eff, len_eff;
    logic [31:0]               sym_ext;
    logic [SYMBOL_WIDTH-1:0]   in_sym;
    lcs_pkg::cell_ctrl_t       ctrl;
    logic [MAX_LEN-1:0]        load_sel;
    logic [MAX_LEN-1:0]        used;
    lcs_pkg::token_t           tok [MAX_LEN+1];
    lcs_pkg::cell_out_t        cout [MAX_LEN];
    lcs_pkg::cell_out_t        cell_or;

    logic                      ram_we, ram_re;
    logic [AW-1:0]             ram_waddr, ram_raddr;
    logic [1:0]                ram_rdata;
    logic [1:0]                tr_dir;
    logic                      tr_done;

    assign accept  = start && (state_reg == S_IDLE);
    assign busy    = (state_reg != S_IDLE);
    assign strobe  = strobe_reg;
    assign result  = res_reg;

    // Symbol as stored: sign-extended or cut to the compare width.
    assign sym_ext = {{(32 - lcs_pkg::SYM_W){item.symbol[lcs_pkg::SYM_W-1]}}, item.symbol};
    assign in_sym  = sym_ext[SYMBOL_WIDTH-1:0];

    // Sizes as the item sees them once a new problem has cleared them.
    assign b_eff   = item.first ? '0 : b_len_reg;
    assign a_eff   = item.first ? '0 : a_len_reg;
    assign len_eff = item.first ? '0 : len_reg;

    // Per-cell select lines.
    always_comb
    begin
        for (int k = 0; k < MAX_LEN; k++)
        begin
            load_sel[k] = (32'(b_eff) == k);
            used[k]     = (32'(b_len_reg) > k);
        end
    end

    // Chain of column cells.
    assign tok[0] = tok0_reg;
    for (genvar g = 0; g < MAX_LEN; g++)
    begin : g_cell
        lcs_cell #(
            .SYMBOL_WIDTH(SYMBOL_WIDTH)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .load_sel   (load_sel[g]),
            .used       (used[g]),
            .load_symbol(in_sym),
            .cmp_symbol (sym_reg),
            .tok_in     (tok[g]),
            .tok_out    (tok[g+1]),
            .cell_out   (cout[g])
        );
    end

    // Only the active cell reports nonzero, so an OR picks it out.
    always_comb
    begin
        cell_or = '0;
        for (int k = 0; k < MAX_LEN; k++)
        begin
            cell_or.value     = cell_or.value | cout[k].value;
            cell_or.direction = cell_or.direction | cout[k].direction;
        end
    end

    // Direction memory: one write per wavefront step, one read per path cell.
    assign ram_we    = (state_reg == S_ROW);
    assign ram_waddr = AW'(32'(a_len_reg) * MAX_LEN + 32'(col_reg));
    assign ram_re    = (state_reg == S_TR_ADDR);
    assign ram_raddr = AW'((32'(tr_i_reg) - 1) * MAX_LEN + (32'(tr_j_reg) - 1));

    lcs_ram #(
        .WIDTH(2),
        .DEPTH(DEPTH)
    ) u_dir_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(cell_or.direction),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign tr_dir  = ram_rdata;
    assign tr_done = (tr_dir == lcs_pkg::DIR_EDGE)
                  || (32'(tr_k_reg) + 1 >= 2 * MAX_LEN);

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        b_len_next      = b_len_reg;
        a_len_next      = a_len_reg;
        len_next        = len_reg;
        col_next        = col_reg;
        tr_i_next       = tr_i_reg;
        tr_j_next       = tr_j_reg;
        tr_k_next       = tr_k_reg;
        sym_next        = sym_reg;
        tok0_next       = tok0_reg;
        tok0_next.active = 1'b0;
        res_next        = res_reg;
        strobe_next     = 1'b0;
        ctrl            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ctrl.clear_rows = item.first;
                    if (item.first)
                    begin
                        b_len_next = '0;
                        a_len_next = '0;
                        len_next   = '0;
                    end
                    res_next.length    = len_eff;
                    res_next.row       = '0;
                    res_next.col       = '0;
                    res_next.direction = lcs_pkg::DIR_EDGE;
                    res_next.overflow  = 1'b0;
                    res_next.last      = 1'b1;

                    unique case (item.operation)
                        lcs_pkg::OP_LOAD:
                        begin
                            strobe_next = 1'b1;
                            if (32'(b_eff) < MAX_LEN)
                            begin
                                // Appending to B drops the rows built so far.
                                ctrl.load       = 1'b1;
                                ctrl.clear_rows = 1'b1;
                                b_len_next      = b_eff + LW'(1);
                                a_len_next      = '0;
                                len_next        = '0;
                                res_next.length = '0;
                            end
                            else
                            begin
                                res_next.overflow = 1'b1;
                            end
                        end
                        lcs_pkg::OP_FEED:
                        begin
                            if (32'(a_eff) >= MAX_LEN)
                            begin
                                strobe_next       = 1'b1;
                                res_next.overflow = 1'b1;
                            end
                            else if (b_eff == '0)
                            begin
                                // Empty B: the row is just the zero edge.
                                strobe_next = 1'b1;
                                a_len_next  = a_eff + LW'(1);
                            end
                            else
                            begin
                                // Launch the wavefront into the first cell.
                                sym_next           = in_sym;
                                tok0_next.active   = 1'b1;
                                tok0_next.left_new = '0;
                                tok0_next.left_old = '0;
                                col_next           = '0;
                                state_next         = S_ROW;
                            end
                        end
                        lcs_pkg::OP_TRACE:
                        begin
                            tr_i_next  = a_eff;
                            tr_j_next  = b_eff;
                            tr_k_next  = '0;
                            state_next = S_TR_ADDR;
                        end
                        default:
                        begin
                            strobe_next = 1'b1;
                        end
                    endcase
                end
            end

            S_ROW:
            begin
                col_next = col_reg + LW'(1);
                if (col_reg == b_len_reg - LW'(1))
                begin
                    // Last column of B: its value is the LCS so far.
                    len_next           = cell_or.value;
                    a_len_next         = a_len_reg + LW'(1);
                    res_next.length    = cell_or.value;
                    res_next.row       = '0;
                    res_next.col       = '0;
                    res_next.direction = lcs_pkg::DIR_EDGE;
                    res_next.overflow  = 1'b0;
                    res_next.last      = 1'b1;
                    strobe_next        = 1'b1;
                    state_next         = S_IDLE;
                end
            end

            S_TR_ADDR:
            begin
                if (tr_i_reg != '0 && tr_j_reg != '0)
                begin
                    state_next = S_TR_DATA;
                end
                else
                begin
                    // Reached row 0 or column 0: the edge cell ends the run.
                    res_next.length    = len_reg;
                    res_next.row       = tr_i_reg;
                    res_next.col       = tr_j_reg;
                    res_next.direction = lcs_pkg::DIR_EDGE;
                    res_next.overflow  = 1'b0;
                    res_next.last      = 1'b1;
                    strobe_next        = 1'b1;
                    state_next         = S_IDLE;
                end
            end

            S_TR_DATA:
            begin
                res_next.length    = len_reg;
                res_next.row       = tr_i_reg;
                res_next.col       = tr_j_reg;
                res_next.direction = tr_dir;
                res_next.overflow  = 1'b0;
                res_next.last      = tr_done;
                strobe_next        = 1'b1;
                tr_k_next          = tr_k_reg + lcs_pkg::CNT_W'(1);
                if (tr_done)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_TR_ADDR;
                    unique case (tr_dir)
                        lcs_pkg::DIR_DIAG:
                        begin
                            tr_i_next = tr_i_reg - LW'(1);
                            tr_j_next = tr_j_reg - LW'(1);
                        end
                        lcs_pkg::DIR_UP:
                        begin
                            tr_i_next = tr_i_reg - LW'(1);
                        end
                        default:
                        begin
                            tr_j_next = tr_j_reg - LW'(1);
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            b_len_reg  <= '0;
            a_len_reg  <= '0;
            len_reg    <= '0;
            tok0_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            b_len_reg  <= b_len_next;
            a_len_reg  <= a_len_next;
            len_reg    <= len_next;
            tok0_reg   <= tok0_next;
            strobe_reg <= strobe_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        col_reg  <= col_next;
        tr_i_reg <= tr_i_next;
        tr_j_reg <= tr_j_next;
        tr_k_reg <= tr_k_next;
        sym_reg  <= sym_next;
        res_reg  <= res_next;
    end

endmodule
